// File: hdl/ffa_pkg.sv
package ffa_pkg;

	localparam int HEAP_BYTES = 65536;
	localparam int SLOT_COUNT = HEAP_BYTES / 8;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);
	localparam int NEED_W     = 14;
	localparam logic [SLOT_W-1:0] END_SLOT = SLOT_W'(SLOT_COUNT - 1);
	// highest slot whose data address still fits in 16 bits
	localparam logic [SLOT_W:0] LAST_DATA_SLOT = (SLOT_W+1)'(16'hFFFF >> 3);
	localparam logic [NEED_W-1:0] MIN_SLOTS   = NEED_W'(3);
	localparam logic [SLOT_W:0]   SPLIT_SLOTS = (SLOT_W+1)'(4);

	typedef enum logic [1:0] {
		ST_NONE = 2'd0,
		ST_FREE = 2'd1,
		ST_USED = 2'd2,
		ST_END  = 2'd3
	} hst_t;

	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef struct packed {
		hst_t              st;
		logic [SLOT_W-1:0] nxt;
	} hdr_t;

	typedef enum logic [1:0] {
		RD_NONE = 2'd0,
		RD_CUR  = 2'd1,
		RD_LINK = 2'd2
	} rd_sel_t;

	typedef enum logic [2:0] {
		WR_NONE  = 3'd0,
		WR_SPLIT = 3'd1,
		WR_USE   = 3'd2,
		WR_FREE  = 3'd3,
		WR_PREV  = 3'd4
	} wr_sel_t;

	typedef enum logic [1:0] {
		RES_NONE  = 2'd0,
		RES_GRANT = 2'd1,
		RES_OK    = 2'd2,
		RES_FAIL  = 2'd3
	} res_sel_t;

	typedef struct packed {
		logic     start;
		rd_sel_t  rd;
		logic     adv;
		logic     keep_next;
		logic     merge_next;
		logic     split_next;
		wr_sel_t  wr;
		res_sel_t res;
	} ffa_cmd_t;

	typedef struct packed {
		logic at_end;
		logic before_t;
		logic at_t;
		logic fit;
		logic split;
		logic cur_used;
		logic can_merge;
		logic prev_free;
		logic addr_zero;
		logic misaligned;
	} ffa_sts_t;

endpackage

// File: hdl/ffa_req_if.sv
interface ffa_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [15:0] request_bytes;
	logic [15:0] block_address;

	modport source(output valid, output operation, output request_bytes,
		output block_address, input ready);
	modport sink(input valid, input operation, input request_bytes,
		input block_address, output ready);
endinterface

// File: hdl/ffa_rsp_if.sv
interface ffa_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] granted_address;
	logic        success;

	modport source(output valid, output granted_address, output success, input ready);
	modport sink(input valid, input granted_address, input success, output ready);
endinterface

// File: hdl/ffa_datapath.sv
module ffa_datapath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ffa_pkg::ffa_cmd_t        cmd,
	input  logic [15:0]              in_bytes,
	input  logic [15:0]              in_addr,
	output ffa_pkg::ffa_sts_t        sts,
	output logic [15:0]              granted,
	output logic                     ok
);
	ffa_pkg::hdr_t                     mem [ffa_pkg::SLOT_COUNT];
	ffa_pkg::hdr_t                     rd_q;
	ffa_pkg::hdr_t                     rdata;
	ffa_pkg::hdr_t                     wdata;
	logic                              rd_zero_q;
	logic                              slot0_written_q;
	logic [ffa_pkg::SLOT_W-1:0]        s_q, prev_q, t_q, nxt_q;
	logic [ffa_pkg::NEED_W-1:0]        need_q;
	logic                              prev_free_q, has_prev_q;
	logic [15:0]                       addr_q;
	logic [ffa_pkg::SLOT_W-1:0]        rd_addr, wr_addr, ns;
	logic [ffa_pkg::SLOT_W:0]          size;
	logic [ffa_pkg::NEED_W-1:0]        need_raw;
	logic [16:0]                       bytes_up;

	assign bytes_up = {1'b0, in_bytes} + 17'd7;
	assign need_raw = bytes_up[16:3];

	// slot 0 reads as the reset chunk until first written
	assign rdata = (rd_zero_q && !slot0_written_q) ?
		ffa_pkg::hdr_t'{st: ffa_pkg::ST_FREE, nxt: ffa_pkg::END_SLOT} : rd_q;

	assign size = {1'b0, rdata.nxt} - {1'b0, s_q} - (ffa_pkg::SLOT_W+1)'(1);
	assign ns   = s_q + ffa_pkg::SLOT_W'(1) + ffa_pkg::SLOT_W'(need_q);

	always_comb begin
		sts.at_end     = (s_q >= ffa_pkg::END_SLOT);
		sts.before_t   = (s_q < t_q);
		sts.at_t       = (s_q == t_q);
		sts.fit        = (rdata.st == ffa_pkg::ST_FREE) && (size >= need_q)
			&& ({1'b0, s_q} + (ffa_pkg::SLOT_W+1)'(1) <= ffa_pkg::LAST_DATA_SLOT);
		sts.split      = (size - need_q) >= ffa_pkg::SPLIT_SLOTS;
		sts.cur_used   = (rdata.st == ffa_pkg::ST_USED);
		sts.can_merge  = (nxt_q < ffa_pkg::END_SLOT) && (rdata.st == ffa_pkg::ST_FREE);
		sts.prev_free  = has_prev_q && prev_free_q;
		sts.addr_zero  = (addr_q == 16'd0);
		sts.misaligned = (addr_q[2:0] != 3'd0);
	end

	always_comb begin
		case (cmd.rd)
			ffa_pkg::RD_LINK: rd_addr = rdata.nxt;
			default:          rd_addr = s_q;
		endcase
		case (cmd.wr)
			ffa_pkg::WR_SPLIT: begin
				wr_addr = ns;
				wdata   = '{st: ffa_pkg::ST_FREE, nxt: rdata.nxt};
			end
			ffa_pkg::WR_USE: begin
				wr_addr = s_q;
				wdata   = '{st: ffa_pkg::ST_USED, nxt: nxt_q};
			end
			ffa_pkg::WR_PREV: begin
				wr_addr = prev_q;
				wdata   = '{st: ffa_pkg::ST_FREE, nxt: nxt_q};
			end
			default: begin
				wr_addr = t_q;
				wdata   = '{st: ffa_pkg::ST_FREE, nxt: nxt_q};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr != ffa_pkg::WR_NONE) begin
			mem[wr_addr] <= wdata;
		end
		if (cmd.rd != ffa_pkg::RD_NONE) begin
			rd_q      <= mem[rd_addr];
			rd_zero_q <= (rd_addr == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot0_written_q <= 1'b0;
			granted         <= 16'd0;
			ok              <= 1'b0;
		end else begin
			if (cmd.wr != ffa_pkg::WR_NONE && wr_addr == '0) begin
				slot0_written_q <= 1'b1;
			end
			case (cmd.res)
				ffa_pkg::RES_GRANT: begin
					granted <= 16'({s_q + ffa_pkg::SLOT_W'(1), 3'b000});
					ok      <= 1'b1;
				end
				ffa_pkg::RES_OK: begin
					granted <= 16'd0;
					ok      <= 1'b1;
				end
				ffa_pkg::RES_FAIL: begin
					granted <= 16'd0;
					ok      <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			addr_q      <= in_addr;
			need_q      <= (need_raw < ffa_pkg::MIN_SLOTS) ? ffa_pkg::MIN_SLOTS : need_raw;
			t_q         <= ffa_pkg::SLOT_W'(in_addr[15:3]) - ffa_pkg::SLOT_W'(1);
			s_q         <= '0;
			has_prev_q  <= 1'b0;
		end else if (cmd.adv) begin
			prev_q      <= s_q;
			prev_free_q <= (rdata.st == ffa_pkg::ST_FREE);
			has_prev_q  <= 1'b1;
			s_q         <= rdata.nxt;
		end
		if (cmd.keep_next) begin
			nxt_q <= rdata.nxt;
		end else if (cmd.split_next) begin
			nxt_q <= ns;
		end else if (cmd.merge_next && sts.can_merge) begin
			nxt_q <= rdata.nxt;
		end
	end

endmodule

// File: hdl/ffa_ctrl.sv
module ffa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_op,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  ffa_pkg::ffa_sts_t   sts,
	output ffa_pkg::ffa_cmd_t   cmd
);
	typedef enum logic [3:0] {
		IDLE, CHECK_REL, A_RD, A_CHK, A_SPL, A_USE, R_RD, R_ADV, R_CHK, R_MRG, R_WR
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '{start: 1'b0, rd: ffa_pkg::RD_NONE, adv: 1'b0, keep_next: 1'b0,
			merge_next: 1'b0, split_next: 1'b0, wr: ffa_pkg::WR_NONE,
			res: ffa_pkg::RES_NONE};
		case (state_q)
			IDLE:      cmd.start = in_valid && in_ready;
			CHECK_REL: begin
				if (sts.addr_zero) begin
					cmd.res = ffa_pkg::RES_OK;
				end else if (sts.misaligned) begin
					cmd.res = ffa_pkg::RES_FAIL;
				end
			end
			A_RD: begin
				if (sts.at_end) begin
					cmd.res = ffa_pkg::RES_FAIL;
				end else begin
					cmd.rd = ffa_pkg::RD_CUR;
				end
			end
			A_CHK: begin
				cmd.keep_next = 1'b1;
				cmd.adv       = !sts.fit;
			end
			A_SPL: begin
				cmd.wr         = ffa_pkg::WR_SPLIT;
				cmd.split_next = 1'b1;
			end
			A_USE: begin
				cmd.wr  = ffa_pkg::WR_USE;
				cmd.res = ffa_pkg::RES_GRANT;
			end
			R_RD: begin
				if (!sts.at_end && sts.before_t) begin
					cmd.rd = ffa_pkg::RD_CUR;
				end else if (sts.at_t && !sts.at_end) begin
					cmd.rd = ffa_pkg::RD_CUR;
				end else begin
					cmd.res = ffa_pkg::RES_FAIL;
				end
			end
			R_ADV: cmd.adv = 1'b1;
			R_CHK: begin
				if (sts.cur_used) begin
					cmd.keep_next = 1'b1;
					cmd.rd        = ffa_pkg::RD_LINK;
				end else begin
					cmd.res = ffa_pkg::RES_FAIL;
				end
			end
			R_MRG: cmd.merge_next = 1'b1;
			R_WR: begin
				cmd.wr  = sts.prev_free ? ffa_pkg::WR_PREV : ffa_pkg::WR_FREE;
				cmd.res = ffa_pkg::RES_OK;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.res != ffa_pkg::RES_NONE) begin
				out_valid_q <= 1'b1;
			end
			case (state_q)
				IDLE: begin
					if (in_valid && in_ready) begin
						state_q <= (in_op == ffa_pkg::OP_RELEASE) ? CHECK_REL : A_RD;
					end
				end
				CHECK_REL: state_q <= (sts.addr_zero || sts.misaligned) ? IDLE : R_RD;
				A_RD:      state_q <= sts.at_end ? IDLE : A_CHK;
				A_CHK:     state_q <= !sts.fit ? A_RD : (sts.split ? A_SPL : A_USE);
				A_SPL:     state_q <= A_USE;
				A_USE:     state_q <= IDLE;
				R_RD: begin
					if (!sts.at_end && sts.before_t) begin
						state_q <= R_ADV;
					end else if (sts.at_t && !sts.at_end) begin
						state_q <= R_CHK;
					end else begin
						state_q <= IDLE;
					end
				end
				R_ADV:     state_q <= R_RD;
				R_CHK:     state_q <= sts.cur_used ? R_MRG : IDLE;
				R_MRG:     state_q <= R_WR;
				R_WR:      state_q <= IDLE;
				default:   state_q <= IDLE;
			endcase
		end
	end

	// no header write while waiting for a request
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == IDLE |-> cmd.wr == ffa_pkg::WR_NONE)
		else $error("header write while idle");

	// a new result never lands on one not yet taken
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res != ffa_pkg::RES_NONE |-> !out_valid_q)
		else $error("result overwritten");

	// each accepted beat leaves the idle state
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q != IDLE)
		else $error("accepted beat dropped");

endmodule

// File: hdl/first_fit_heap_allocator_top.sv
// channel | role   | payload
// req     | sink   | operation, request_bytes, block_address
// rsp     | source | granted_address, success
//
// One request at a time. Allocate: a read and a fit check per chunk visited in address
// order, then header writes (a split if the rest is large enough, then use) or a no-fit report.
// Release: an address check, a read and an advance per chunk before the target, then
// read, check, merge, write. The walk through the single-port header memory sets the time.
// Reset leaves the heap as one free chunk at once, with no clearing pass.
// req is not ready until the previous result beat has been taken on rsp.
module first_fit_heap_allocator_top (
	input  logic       clk,
	input  logic       arst_n,
	ffa_req_if.sink    req,
	ffa_rsp_if.source  rsp
);
	ffa_pkg::ffa_cmd_t cmd;
	ffa_pkg::ffa_sts_t sts;

	ffa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_op     (req.operation),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ffa_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_bytes (req.request_bytes),
		.in_addr  (req.block_address),
		.sts      (sts),
		.granted  (rsp.granted_address),
		.ok       (rsp.success)
	);

endmodule

// File: dv/first_fit_heap_allocator_top_tb.sv
module first_fit_heap_allocator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOT = 8192;
	localparam int LAST = NSLOT - 1;
	localparam int WATCHDOG = 200000;

	typedef struct packed {
		ffa_pkg::op_t op;
		logic [15:0]  bytes;
		logic [15:0]  addr;
	} heap_req_t;

	typedef struct packed {
		logic [15:0] granted;
		logic        ok;
	} heap_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ffa_req_if req_ch();
	ffa_rsp_if rsp_ch();

	first_fit_heap_allocator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow heap
	int            link_of [NSLOT];
	ffa_pkg::hst_t state_of [NSLOT];
	int            live_blocks [$];

	heap_req_t pending_reqs [$];
	heap_rsp_t awaited_rsps [$];

	int   mismatches = 0;
	int   grants = 0;
	int   releases = 0;
	int   no_fits = 0;
	int   quiet_cycles = 0;
	logic timed_out = 1'b0;
	logic calm = 1'b0;
	logic hold_send = 1'b0;

	function automatic void heap_clear();
		for (int i = 0; i < NSLOT; i++) begin
			link_of[i] = 0;
			state_of[i] = ffa_pkg::ST_NONE;
		end
		state_of[0] = ffa_pkg::ST_FREE;
		link_of[0] = LAST;
		state_of[LAST] = ffa_pkg::ST_END;
		link_of[LAST] = LAST;
	endfunction

	function automatic heap_rsp_t heap_alloc(int bytes);
		heap_rsp_t r;
		int want;
		int s;
		int dsz;
		int ns;
		r = '0;
		want = (bytes + 7) & ~7;
		if (want < 24)
			want = 24;
		s = 0;
		while (s < LAST) begin
			if (state_of[s] == ffa_pkg::ST_FREE) begin
				dsz = (link_of[s] - s - 1) * 8;
				if (dsz >= want && (s + 1) * 8 <= 16'hFFFF) begin
					if (dsz - want >= 32) begin
						ns = s + 1 + want / 8;
						state_of[ns] = ffa_pkg::ST_FREE;
						link_of[ns] = link_of[s];
						link_of[s] = ns;
					end
					state_of[s] = ffa_pkg::ST_USED;
					r.granted = 16'((s + 1) * 8);
					r.ok = 1'b1;
					return r;
				end
			end
			s = link_of[s];
		end
		return r;
	endfunction

	function automatic logic heap_release(int addr);
		int t;
		int s;
		int prv;
		int n;
		logic has_prv;
		s = 0;
		prv = 0;
		has_prv = 1'b0;
		if (addr == 0)
			return 1'b1;
		if ((addr & 7) != 0)
			return 1'b0;
		t = addr / 8 - 1;
		while (s < LAST && s < t) begin
			prv = s;
			has_prv = 1'b1;
			s = link_of[s];
		end
		if (s != t || s >= LAST || state_of[s] != ffa_pkg::ST_USED)
			return 1'b0;
		n = link_of[t];
		if (n < LAST && state_of[n] == ffa_pkg::ST_FREE) begin
			link_of[t] = link_of[n];
			state_of[n] = ffa_pkg::ST_NONE;
		end
		state_of[t] = ffa_pkg::ST_FREE;
		if (has_prv && state_of[prv] == ffa_pkg::ST_FREE) begin
			link_of[prv] = link_of[t];
			state_of[t] = ffa_pkg::ST_NONE;
		end
		return 1'b1;
	endfunction

	function automatic heap_rsp_t heap_predict(heap_req_t it);
		heap_rsp_t r;
		if (it.op == ffa_pkg::OP_ALLOC) begin
			r = heap_alloc(int'(it.bytes));
		end else begin
			r.granted = '0;
			r.ok = heap_release(int'(it.addr));
		end
		return r;
	endfunction

	// driver
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.operation <= ffa_pkg::OP_ALLOC;
			req_ch.request_bytes <= '0;
			req_ch.block_address <= '0;
			gap_left = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				awaited_rsps.push_back(heap_predict(pending_reqs.pop_front()));
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_ch.valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 5) == 0) begin
					gap_left = $urandom_range(0, 3);
					req_ch.valid <= 1'b0;
				end else if (pending_reqs.size() > 0 && !hold_send) begin
					req_ch.valid <= 1'b1;
					req_ch.operation <= pending_reqs[0].op;
					req_ch.request_bytes <= pending_reqs[0].bytes;
					req_ch.block_address <= pending_reqs[0].addr;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver stalls
	int stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		heap_rsp_t got;
		heap_rsp_t exp;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.granted = rsp_ch.granted_address;
				got.ok = rsp_ch.success;
				if (awaited_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected beat: granted %h success %b",
							got.granted, got.ok);
				end else begin
					exp = awaited_rsps.pop_front();
					if (got.granted !== exp.granted || got.ok !== exp.ok) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp %h/%b got %h/%b",
								exp.granted, exp.ok, got.granted, got.ok);
					end else if (exp.granted != 0) begin
						grants++;
					end
					if (!exp.ok)
						no_fits++;
				end
			end
			if (req_ch.valid && req_ch.ready || rsp_ch.valid && rsp_ch.ready)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG)
				timed_out = 1'b1;
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 3);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// saved copy of the shadow heap, so planning can rewind it afterwards
	int            sim_link [NSLOT];
	ffa_pkg::hst_t sim_state [NSLOT];

	function automatic void add_req(ffa_pkg::op_t op, int bytes, int addr);
		heap_req_t it;
		it.op = op;
		it.bytes = 16'(bytes);
		it.addr = 16'(addr);
		pending_reqs.push_back(it);
		if (op == ffa_pkg::OP_RELEASE)
			releases++;
	endfunction

	function automatic int pick_size();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 65535);
			1: return $urandom_range(1024, 8192);
			default: return $urandom_range(0, 300);
		endcase
	endfunction

	// build stimulus, advancing the shared shadow to learn live addresses
	task automatic plan_random(int count);
		heap_rsp_t r;
		heap_req_t it;
		int idx;
		int a;
		int kind;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 50 || live_blocks.size() == 0) begin
				it.op = ffa_pkg::OP_ALLOC;
				it.bytes = 16'(pick_size());
				it.addr = 16'($urandom);
			end else if (kind < 90) begin
				idx = $urandom_range(0, live_blocks.size() - 1);
				it.op = ffa_pkg::OP_RELEASE;
				it.bytes = 16'($urandom);
				it.addr = 16'(live_blocks[idx]);
				live_blocks.delete(idx);
			end else begin
				it.op = ffa_pkg::OP_RELEASE;
				it.bytes = 16'($urandom);
				a = $urandom;
				it.addr = (kind < 93) ? 16'(a & 16'hFFF8) : 16'(a);
			end
			// advance the planning shadow
			r = heap_predict(it);
			if (it.op == ffa_pkg::OP_ALLOC && r.ok)
				live_blocks.push_back(r.granted);
			if (it.op == ffa_pkg::OP_RELEASE && r.ok && it.addr != 0)
				foreach (live_blocks[j])
					if (live_blocks[j] == it.addr) begin
						live_blocks.delete(j);
						break;
					end
			pending_reqs.push_back(it);
			if (it.op == ffa_pkg::OP_RELEASE)
				releases++;
		end
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || awaited_rsps.size() > 0) begin
			@(posedge clk);
			if (timed_out)
				return;
		end
	endtask

	// planning and checking share the shadow: plan with it, then rewind
	task automatic plan_phase(int count, logic directed);
		for (int i = 0; i < NSLOT; i++) begin
			sim_link[i] = link_of[i];
			sim_state[i] = state_of[i];
		end
		if (directed) begin
			add_req(ffa_pkg::OP_ALLOC, 0, 16'hFFFF);
			add_req(ffa_pkg::OP_ALLOC, 24, 0);
			add_req(ffa_pkg::OP_ALLOC, 25, 0);
			add_req(ffa_pkg::OP_ALLOC, 65535, 0);
			add_req(ffa_pkg::OP_RELEASE, 16'hFFFF, 0);
			add_req(ffa_pkg::OP_RELEASE, 0, 16'h0011);
			add_req(ffa_pkg::OP_RELEASE, 0, 16'hFFF8);
			add_req(ffa_pkg::OP_RELEASE, 0, 16'hFFFF);
			add_req(ffa_pkg::OP_RELEASE, 0, 8);
			add_req(ffa_pkg::OP_RELEASE, 0, 8);
			add_req(ffa_pkg::OP_RELEASE, 0, 48);
			add_req(ffa_pkg::OP_ALLOC, 16, 0);
			add_req(ffa_pkg::OP_ALLOC, 40, 0);
			add_req(ffa_pkg::OP_ALLOC, 64, 0);
			add_req(ffa_pkg::OP_RELEASE, 0, 48);
			add_req(ffa_pkg::OP_RELEASE, 0, 8);
			add_req(ffa_pkg::OP_RELEASE, 0, 88);
			add_req(ffa_pkg::OP_ALLOC, 65000, 0);
			add_req(ffa_pkg::OP_ALLOC, 100, 0);
			add_req(ffa_pkg::OP_RELEASE, 0, 8);
			foreach (pending_reqs[i])
				void'(heap_predict(pending_reqs[i]));
		end else begin
			plan_random(count);
		end
		for (int i = 0; i < NSLOT; i++) begin
			link_of[i] = sim_link[i];
			state_of[i] = sim_state[i];
		end
	endtask

	initial begin
		heap_clear();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		plan_phase(0, 1'b1);
		drain();
		// the live list is empty after the directed part
		live_blocks.delete();
		for (int p = 0; p < 6 && !timed_out; p++) begin
			if (p == 5)
				calm = 1'b1;
			if (p == 2)
				hold_send = 1'b1;
			plan_phase(305, 1'b0);
			if (p == 2) begin
				// let the sender go again; it was held while this phase was planned
				hold_send = 1'b0;
			end
			drain();
		end
		if (!timed_out)
			repeat (400) @(posedge clk);
		if (timed_out) begin
			$display("first_fit_heap_allocator_top verification failed");
		end else begin
			$display("covered %0d grants, %0d releases, %0d refused beats",
				grants, releases, no_fits);
			if (mismatches == 0 && awaited_rsps.size() == 0)
				$display("first_fit_heap_allocator_top verification clean");
			else
				$display("first_fit_heap_allocator_top verification failed");
		end
		$finish;
	end
endmodule
